[design/rss_pkg.sv]
// ----------------------------------------------------------------------------
// rss_pkg: shared types for the running sample statistics block
// Snapshot word passed from the accumulator front end to the variance back end,
// plus the fixed field widths of the result word.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int SMP_W   = 16;   // sample, minimum, maximum
  localparam int CNT_W   = 31;   // count field
  localparam int TOT_W   = 47;   // total field
  localparam int SQS_W   = 61;   // total_squares field
  localparam int VAR_W   = 32;   // variance field
  localparam int DEV_W   = 16;   // deviation field

  // Snapshot widths cover the widest parameter settings.
  localparam int SNAP_CNT_W = 32;
  localparam int SNAP_ACC_W = 64;
  localparam int SNAP_SMP_W = 24;

  typedef struct packed {
    logic [SNAP_CNT_W-1:0]        count;
    logic signed [SNAP_SMP_W-1:0] low;
    logic signed [SNAP_SMP_W-1:0] high;
    logic signed [SNAP_ACC_W-1:0] sum;
    logic [SNAP_ACC_W-1:0]        sumsq;
    logic                         ovf;
  } snap_t;

endpackage

[design/rss_if.sv]
// ----------------------------------------------------------------------------
// rss_if: stream channels of the running sample statistics block
// One sample word in, one statistics word out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rss_in_if import rss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rss_out_if import rss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        count;
  logic signed [SMP_W-1:0] minimum;
  logic signed [SMP_W-1:0] maximum;
  logic signed [TOT_W-1:0] total;
  logic [SQS_W-1:0]        total_squares;
  logic [VAR_W-1:0]        variance;
  logic [DEV_W-1:0]        deviation;
  logic                    overflowed;

  modport source (output valid, output count, output minimum, output maximum,
                  output total, output total_squares, output variance,
                  output deviation, output overflowed, input ready);
  modport sink   (input valid, input count, input minimum, input maximum,
                  input total, input total_squares, input variance,
                  input deviation, input overflowed, output ready);
endinterface

[design/rss_front.sv]
// ----------------------------------------------------------------------------
// rss_front: sample accumulator
// Takes one sample a cycle while the queue has room, updates count, sum,
// sum of squares, minimum, maximum and the sticky overflow flag, and pushes
// the updated snapshot.
// ----------------------------------------------------------------------------
module rss_front import rss_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 31
) (
  input  logic   clk,
  input  logic   rst_n,
  rss_in_if.sink in_s,
  input  logic   full,
  output logic   push,
  output snap_t  push_data
);

  localparam int SUM_W = (SAMPLE_BITS + COUNT_BITS > 64) ? 64 : SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W  = (2*SAMPLE_BITS + COUNT_BITS - 2 > 64) ? 64
                       : 2*SAMPLE_BITS + COUNT_BITS - 2;

  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQ_W-1:0]               sq_r, sq_nxt;
  logic signed [SAMPLE_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic                          ovf_r, ovf_nxt;

  logic [SAMPLE_BITS+SMP_W-1:0]  ext;
  logic [SAMPLE_BITS-1:0]        raw;
  logic signed [SAMPLE_BITS-1:0] val;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [2*SAMPLE_BITS-1:0]      sqr;

  always_comb begin
    // Bits above the sample width are ignored; a wider sample sees the port zero-extended.
    ext = {{SAMPLE_BITS{1'b0}}, in_s.sample};
    raw = ext[SAMPLE_BITS-1:0];
    val = signed'(raw);
    mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    sqr = mag * mag;

    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    ovf_nxt = ovf_r;
    if (!ovf_r) begin
      if (&cnt_r) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        sum_nxt = sum_r + SUM_W'(val);
        sq_nxt  = sq_r + SQ_W'(sqr);
        if (cnt_r == '0) begin
          lo_nxt = val;
          hi_nxt = val;
        end else if (val < lo_r) begin
          lo_nxt = val;
        end else if (val > hi_r) begin
          hi_nxt = val;
        end
      end
    end
  end

  assign in_s.ready = !full;
  assign push       = in_s.valid && !full;

  always_comb begin
    push_data.count = SNAP_CNT_W'(cnt_nxt);
    push_data.low   = SNAP_SMP_W'(lo_nxt);
    push_data.high  = SNAP_SMP_W'(hi_nxt);
    push_data.sum   = SNAP_ACC_W'(sum_nxt);
    push_data.sumsq = SNAP_ACC_W'(sq_nxt);
    push_data.ovf   = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      lo_r  <= '0;
      hi_r  <= '0;
      ovf_r <= 1'b0;
    end else if (push) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

[design/rss_fifo.sv]
// ----------------------------------------------------------------------------
// rss_fifo: short snapshot queue
// Small register queue between the accumulator and the variance sequencer.
// ----------------------------------------------------------------------------
module rss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

[design/rss_back.sv]
// ----------------------------------------------------------------------------
// rss_back: variance and deviation sequencer
// Forms n*S2 and S1^2 with one shared 32x32 multiplier, divides by n*(n-1)
// one quotient bit a cycle, takes the integer square root one bit a cycle and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
module rss_back import rss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  snap_t      snap,
  input  logic       empty,
  output logic       pop,
  rss_out_if.source  out_s
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CMP, S_LIM, S_DIV, S_SQRT, S_DONE
  } state_t;

  // Multiplier schedule: which partial product is formed at each step.
  localparam logic [2:0] MS_A_LO = 3'd0;
  localparam logic [2:0] MS_A_HI = 3'd1;
  localparam logic [2:0] MS_B_LL = 3'd2;
  localparam logic [2:0] MS_B_LH = 3'd3;
  localparam logic [2:0] MS_B_HL = 3'd4;
  localparam logic [2:0] MS_B_HH = 3'd5;
  localparam logic [2:0] MS_DEN  = 3'd6;
  localparam logic [2:0] MS_LAST = 3'd7;

  state_t        state_r;
  snap_t         snap_r;
  logic [63:0]   mag_r;
  logic [2:0]    step_r;
  logic [63:0]   prod_r;
  logic [95:0]   a_r;
  logic [127:0]  b_r;
  logic [63:0]   den_r;
  logic [95:0]   num_r;
  logic [95:0]   t_r;
  logic [31:0]   q_r;
  logic [4:0]    div_cnt_r;
  logic [31:0]   var_r;
  logic [15:0]   root_r;
  logic [15:0]   sbit_r;

  logic                    out_valid_r;
  logic [CNT_W-1:0]        count_r;
  logic signed [SMP_W-1:0] minimum_r, maximum_r;
  logic signed [TOT_W-1:0] total_r;
  logic [SQS_W-1:0]        squares_r;
  logic [VAR_W-1:0]        variance_r;
  logic [DEV_W-1:0]        deviation_r;
  logic                    ovf_out_r;

  logic [31:0] opa, opb;
  logic [63:0] prod;
  logic [2:0]  acc_sel;
  logic        ge;
  logic [15:0] trial;
  logic [31:0] trial_sq;

  always_comb begin
    case (step_r)
      MS_A_LO: begin opa = snap_r.count;  opb = snap_r.sumsq[31:0];  end
      MS_A_HI: begin opa = snap_r.count;  opb = snap_r.sumsq[63:32]; end
      MS_B_LL: begin opa = mag_r[31:0];   opb = mag_r[31:0];         end
      MS_B_LH: begin opa = mag_r[31:0];   opb = mag_r[63:32];        end
      MS_B_HL: begin opa = mag_r[63:32];  opb = mag_r[31:0];         end
      MS_B_HH: begin opa = mag_r[63:32];  opb = mag_r[63:32];        end
      MS_DEN:  begin opa = snap_r.count;  opb = snap_r.count - 1'b1; end
      default: begin opa = '0;            opb = '0;                  end
    endcase
    prod     = opa * opb;
    acc_sel  = step_r - 1'b1;
    ge       = (num_r >= t_r);
    trial    = root_r | sbit_r;
    trial_sq = trial * trial;
  end

  assign pop = (state_r == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A word taken while the next one is ready is replaced in S_DONE.
      if (out_valid_r && out_s.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!empty) begin
            snap_r <= snap;
            mag_r  <= snap.sum[63] ? (~snap.sum + 1'b1) : snap.sum;
            a_r    <= '0;
            b_r    <= '0;
            step_r <= MS_A_LO;
            if (snap.count < SNAP_CNT_W'(2)) begin
              var_r   <= '0;
              root_r  <= '0;
              sbit_r  <= 16'h8000;
              state_r <= S_SQRT;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // Product of this step is registered; the previous one is summed.
          prod_r <= prod;
          if (step_r != MS_A_LO) begin
            case (acc_sel)
              MS_A_LO: a_r   <= a_r + {32'b0, prod_r};
              MS_A_HI: a_r   <= a_r + {prod_r, 32'b0};
              MS_B_LL: b_r   <= b_r + {64'b0, prod_r};
              MS_B_LH: b_r   <= b_r + {32'b0, prod_r, 32'b0};
              MS_B_HL: b_r   <= b_r + {32'b0, prod_r, 32'b0};
              MS_B_HH: b_r   <= b_r + {prod_r, 64'b0};
              MS_DEN:  den_r <= prod_r;
              default: ;
            endcase
          end
          if (step_r == MS_LAST) begin
            state_r <= S_CMP;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_CMP: begin
          if (b_r >= {32'b0, a_r}) begin
            var_r   <= '0;
            root_r  <= '0;
            sbit_r  <= 16'h8000;
            state_r <= S_SQRT;
          end else begin
            num_r   <= a_r - b_r[95:0];
            state_r <= S_LIM;
          end
        end
        S_LIM: begin
          if (num_r >= {den_r, 32'b0}) begin
            var_r   <= '1;
            root_r  <= '0;
            sbit_r  <= 16'h8000;
            state_r <= S_SQRT;
          end else begin
            t_r       <= {1'b0, den_r, 31'b0};
            q_r       <= '0;
            div_cnt_r <= '1;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            num_r <= num_r - t_r;
          end
          q_r <= {q_r[30:0], ge};
          t_r <= t_r >> 1;
          if (div_cnt_r == '0) begin
            var_r   <= {q_r[30:0], ge};
            root_r  <= '0;
            sbit_r  <= 16'h8000;
            state_r <= S_SQRT;
          end else begin
            div_cnt_r <= div_cnt_r - 1'b1;
          end
        end
        S_SQRT: begin
          if (trial_sq <= var_r) begin
            root_r <= trial;
          end
          sbit_r <= sbit_r >> 1;
          if (sbit_r[0]) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_s.ready) begin
            out_valid_r <= 1'b1;
            count_r     <= snap_r.count[CNT_W-1:0];
            minimum_r   <= snap_r.low[SMP_W-1:0];
            maximum_r   <= snap_r.high[SMP_W-1:0];
            total_r     <= snap_r.sum[TOT_W-1:0];
            squares_r   <= snap_r.sumsq[SQS_W-1:0];
            variance_r  <= var_r;
            deviation_r <= root_r;
            ovf_out_r   <= snap_r.ovf;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.count         = count_r;
  assign out_s.minimum       = minimum_r;
  assign out_s.maximum       = maximum_r;
  assign out_s.total         = total_r;
  assign out_s.total_squares = squares_r;
  assign out_s.variance      = variance_r;
  assign out_s.deviation     = deviation_r;
  assign out_s.overflowed    = ovf_out_r;

endmodule

[design/running_sample_statistics_core.sv]
// ----------------------------------------------------------------------------
// running_sample_statistics_core: running count, sum, sum of squares,
// minimum, maximum, unbiased variance and standard deviation of a sample stream
// The back end works on one snapshot at a time: multiplier, 32-step divider, 16-step
// square root; the divider is skipped for fewer than two samples, a zero variance
// or a saturated one. The front end takes words at once while the
// two-entry snapshot queue has room.
// Reset (rst_n low, synchronous) clears the accumulated statistics, the queue and the flag.
// ----------------------------------------------------------------------------
module running_sample_statistics_core import rss_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  rss_in_if.sink    in_s,
  rss_out_if.source out_s
);

  localparam int SNAP_W = $bits(snap_t);

  logic              push, pop, full, empty;
  snap_t             push_data;
  logic [SNAP_W-1:0] rd_data;

  rss_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  rss_fifo #(
    .WIDTH (SNAP_W),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .full      (full),
    .empty     (empty)
  );

  rss_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .snap  (snap_t'(rd_data)),
    .empty (empty),
    .pop   (pop),
    .out_s (out_s)
  );

  // The deviation is the floor square root of the variance.
  a_dev_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |->
      (33'(out_s.deviation) * 33'(out_s.deviation) <= 33'(out_s.variance)) &&
      ((33'(out_s.deviation) + 33'd1) * (33'(out_s.deviation) + 33'd1)
        > 33'(out_s.variance)))
    else $error("deviation is not the floor square root of variance");

  // Once reported, overflow stays set on every later word.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.ready && out_s.overflowed |=>
      !out_s.valid || out_s.overflowed)
    else $error("overflow flag dropped");

  // With at least one sample the minimum never exceeds the maximum.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && (out_s.count != '0) |-> out_s.minimum <= out_s.maximum)
    else $error("minimum above maximum");

  // No word is pushed while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

endmodule
